>>> src/rbuc_pkg.sv
// Shared types and constants for the record blocking/unblocking converter.
`default_nettype none
package rbuc_pkg;

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_EOI  = 2'd1;
    localparam logic [1:0] OP_TWR  = 2'd2;

    localparam logic [1:0] MODE_COPY    = 2'd0;
    localparam logic [1:0] MODE_BLOCK   = 2'd1;
    localparam logic [1:0] MODE_UNBLOCK = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_RECLEN = 2'd1;
    localparam logic [1:0] REG_XLATE  = 2'd2;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [7:0] run_byte;
        logic [5:0] run_cnt;
        logic       run_tr;
        logic       b_valid;
        logic [7:0] b_byte;
        logic       b_tr;
        logic       nl_valid;
        logic       nl_short;
    } t_cmd;

endpackage
`default_nettype wire

>>> src/rbuc_front.sv
// Front end: translation table, stream state tracking and command generation.
`default_nettype none
module rbuc_front
    import rbuc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_table_index,
    input  wire logic [7:0] i_table_value,
    input  wire logic [1:0] i_mode,
    input  wire logic [5:0] i_len,
    input  wire logic       i_xlate,
    output logic            o_busy,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [7:0] r_table [256];
    logic [7:0] r_rd_data;
    logic [7:0] rd_addr;

    logic       r_s1_valid;
    logic       r_s1_eoi;
    logic [7:0] r_s1_raw;
    logic [7:0] r_s1_addr;

    logic [5:0] r_col, n_col;
    logic       r_disc, n_disc;
    logic [5:0] r_pend, n_pend;

    logic       s0_load;

    assign s0_load = i_accept && (i_op == OP_DATA || i_op == OP_EOI);

    always_comb begin
        if (i_op == OP_DATA && !(i_mode == MODE_BLOCK && i_data_byte == CH_NL)) begin
            rd_addr = i_data_byte;
        end else begin
            rd_addr = CH_SP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_op == OP_TWR) begin
            r_table[i_table_index] <= i_table_value;
        end
        if (s0_load) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= s0_load;
        end
        if (s0_load) begin
            r_s1_eoi  <= (i_op == OP_EOI);
            r_s1_raw  <= i_data_byte;
            r_s1_addr <= rd_addr;
        end
    end

    always_comb begin
        logic [7:0] x;
        logic [5:0] col1;
        t_cmd       c;
        logic       push;
        x      = i_xlate ? r_rd_data : r_s1_addr;
        col1   = r_col + 6'd1;
        c      = '0;
        push   = 1'b0;
        n_col  = r_col;
        n_disc = r_disc;
        n_pend = r_pend;
        if (r_s1_valid) begin
            if (r_s1_eoi) begin
                case (i_mode)
                    MODE_BLOCK: begin
                        if (!r_disc && r_col != 6'd0 && r_col < i_len) begin
                            c.run_byte = x;
                            c.run_cnt  = i_len - r_col;
                            c.run_tr   = 1'b1;
                            push       = 1'b1;
                        end
                    end
                    MODE_UNBLOCK: begin
                        if (r_col != 6'd0) begin
                            c.nl_valid = 1'b1;
                            c.nl_short = 1'b1;
                            push       = 1'b1;
                        end
                    end
                    default: ;
                endcase
                n_col  = 6'd0;
                n_disc = 1'b0;
                n_pend = 6'd0;
            end else begin
                case (i_mode)
                    MODE_BLOCK: begin
                        if (r_disc) begin
                            if (r_s1_raw == CH_NL) begin
                                n_disc = 1'b0;
                            end
                        end else if (r_s1_raw == CH_NL) begin
                            if (r_col < i_len) begin
                                c.run_byte = x;
                                c.run_cnt  = i_len - r_col;
                                push       = 1'b1;
                            end
                            n_col = 6'd0;
                        end else begin
                            c.b_valid = 1'b1;
                            c.b_byte  = x;
                            push      = 1'b1;
                            if (col1 >= i_len) begin
                                c.b_tr = 1'b1;
                                n_col  = 6'd0;
                                n_disc = 1'b1;
                            end else begin
                                n_col = col1;
                            end
                        end
                    end
                    MODE_UNBLOCK: begin
                        if (x == CH_SP) begin
                            n_pend = r_pend + 6'd1;
                        end else begin
                            c.run_byte = CH_SP;
                            c.run_cnt  = r_pend;
                            c.b_valid  = 1'b1;
                            c.b_byte   = x;
                            push       = 1'b1;
                            n_pend     = 6'd0;
                        end
                        if (col1 >= i_len) begin
                            c.nl_valid = 1'b1;
                            push       = 1'b1;
                            n_col      = 6'd0;
                            n_pend     = 6'd0;
                        end else begin
                            n_col = col1;
                        end
                    end
                    default: begin
                        c.b_valid = 1'b1;
                        c.b_byte  = x;
                        push      = 1'b1;
                    end
                endcase
            end
        end
        o_cmd  = c;
        o_push = push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= 6'd0;
            r_disc <= 1'b0;
            r_pend <= 6'd0;
        end else begin
            r_col  <= n_col;
            r_disc <= n_disc;
            r_pend <= n_pend;
        end
    end

    assign o_busy = r_s1_valid;

endmodule
`default_nettype wire

>>> src/rbuc_fifo.sv
// Command queue between the front end and the output sequencer.
`default_nettype none
module rbuc_fifo
    import rbuc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_pop,
    output t_cmd                   o_head,
    output logic                   o_empty,
    output logic [QCNT_W-1:0]      o_count
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

>>> src/rbuc_back.sv
// Output sequencer: expands commands into result bytes and holds the output register.
`default_nettype none
module rbuc_back
    import rbuc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_head,
    input  wire logic       i_q_empty,
    output logic            o_q_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic            o_truncated,
    output logic            o_short_record
);

    logic [7:0] r_run_byte;
    logic [5:0] r_run_cnt;
    logic       r_run_tr;
    logic       r_b_valid;
    logic [7:0] r_b_byte;
    logic       r_b_tr;
    logic       r_nl_valid;
    logic       r_nl_short;

    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;
    logic       r_ot;
    logic       r_os;

    logic       active;
    logic       emit;
    logic [7:0] e_byte;
    logic       e_last;
    logic       e_tr;
    logic       e_sr;

    assign active  = (r_run_cnt != 6'd0) || r_b_valid || r_nl_valid;
    assign emit    = active && (!r_ov || i_pop);
    assign o_q_pop = !i_q_empty && (!active || (emit && e_last));

    always_comb begin
        e_byte = CH_NL;
        e_last = 1'b1;
        e_tr   = 1'b0;
        e_sr   = 1'b0;
        if (r_run_cnt != 6'd0) begin
            e_byte = r_run_byte;
            e_last = (r_run_cnt == 6'd1) && !r_b_valid && !r_nl_valid;
            e_tr   = r_run_tr && (r_run_cnt == 6'd1);
        end else if (r_b_valid) begin
            e_byte = r_b_byte;
            e_last = !r_nl_valid;
            e_tr   = r_b_tr;
        end else begin
            e_sr = r_nl_short;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt  <= 6'd0;
            r_b_valid  <= 1'b0;
            r_nl_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_run_cnt  <= i_head.run_cnt;
            r_b_valid  <= i_head.b_valid;
            r_nl_valid <= i_head.nl_valid;
        end else if (emit) begin
            if (r_run_cnt != 6'd0) begin
                r_run_cnt <= r_run_cnt - 6'd1;
            end else if (r_b_valid) begin
                r_b_valid <= 1'b0;
            end else begin
                r_nl_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_run_byte <= i_head.run_byte;
            r_run_tr   <= i_head.run_tr;
            r_b_byte   <= i_head.b_byte;
            r_b_tr     <= i_head.b_tr;
            r_nl_short <= i_head.nl_short;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_pop) begin
            r_ov <= 1'b0;
        end
        if (emit) begin
            r_ob <= e_byte;
            r_ol <= e_last;
            r_ot <= e_tr;
            r_os <= e_sr;
        end
    end

    assign o_empty        = !r_ov;
    assign o_out_byte     = r_ob;
    assign o_last         = r_ol;
    assign o_truncated    = r_ot;
    assign o_short_record = r_os;

endmodule
`default_nettype wire

>>> src/record_block_unblock_converter.sv
// Top level of the record blocking/unblocking byte converter.
//
// Input channel: queue style, push/full. Each request carries an op (data byte,
// end of input, translation table write) and its fields. Result channel:
// queue style, empty/pop; each request yields zero or more result bytes with
// last, truncated and short_record flags; last marks a request's final byte.
// Configuration: APB write of mode, record_length and translate_enable at
// byte addresses 0, 4 and 8; pready is always high. Write only while idle.
// Throughput: one input request per cycle while each request yields at most
// one result and the receiver keeps popping. Pad runs, held-back spaces and
// appended newlines are expanded byte by byte in the output sequencer; the
// command queue (4 entries) absorbs them and full rises once the queued
// commands plus a request in the table-read stage reach four.
// The first result of a request passes through the table-read stage, the
// command queue, the sequencer register and the output register.
// Reset clears the stream state, the queue and the output register; table
// contents stay undefined until written. A stalled receiver holds the output
// register and backs up through the queue to full.
`default_nettype none
module record_block_unblock_converter
    import rbuc_pkg::*;
#(
    parameter int MAX_RECORD = 60
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_table_index,
    input  wire logic [7:0]  i_table_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    output logic             o_truncated,
    output logic             o_short_record,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [1:0] r_mode;
    logic [5:0] r_reclen;
    logic       r_xlate;
    logic [5:0] len_eff;
    logic       cfg_wr;

    logic              accept;
    logic              s1_busy;
    logic              q_push;
    t_cmd              q_in;
    logic              q_pop;
    t_cmd              q_head;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_COPY;
            r_reclen <= 6'd60;
            r_xlate  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:   r_mode   <= pwdata[1:0];
                REG_RECLEN: r_reclen <= pwdata[5:0];
                REG_XLATE:  r_xlate  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:   prdata = {30'd0, r_mode};
            REG_RECLEN: prdata = {26'd0, r_reclen};
            REG_XLATE:  prdata = {31'd0, r_xlate};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_reclen == 6'd0) begin
            len_eff = 6'd1;
        end else if (r_reclen > 6'(MAX_RECORD)) begin
            len_eff = 6'(MAX_RECORD);
        end else begin
            len_eff = r_reclen;
        end
    end

    assign full   = ({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_busy}) >= (QCNT_W + 1)'(QDEPTH);
    assign accept = push && !full;

    rbuc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_mode        (r_mode),
        .i_len         (len_eff),
        .i_xlate       (r_xlate),
        .o_busy        (s1_busy),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    rbuc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    rbuc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .o_truncated    (o_truncated),
        .o_short_record (o_short_record)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QCNT_W'(QDEPTH) || q_pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_count != '0)
        else $error("command queue underflow");

    a_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_in.run_cnt != 6'd0 || q_in.b_valid || q_in.nl_valid))
        else $error("empty command queued");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count == QCNT_W'(QDEPTH)) |-> full)
        else $error("input open while queue full");

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the record blocking/unblocking byte converter.
`timescale 1ns / 1ps
module tb;
    import rbuc_pkg::*;

    localparam int MAX_REC = 60;
    localparam int LIMIT_NS = 12_000_000;
    localparam int ITEMS_PER_SETTING = 30;
    localparam int ALPHA_N = 30;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       trunc;
        logic       short_rec;
    } t_out_byte;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] idx;
        logic [7:0] val;
        logic       typed;
        t_out_byte  want;
    } t_dir_row;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] len;
        logic       xl;
    } t_setting;

    localparam t_out_byte NO_OUT = '0;

    localparam t_dir_row DIRECTED [38] = '{
        '{ROW_REQ, OP_DATA,  8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'hFF, 8'h00, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_EOI,   8'h00, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_REQ, OP_SPARE, 8'hAA, 8'hFF, 8'hFF, 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_MODE), 8'(MODE_SPARE), 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h0A, 8'h00, 8'h00, 1'b1, '{8'h0A, 1'b1, 1'b0, 1'b0}},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_MODE), 8'(MODE_BLOCK), 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_RECLEN), 8'd4, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h0A, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h61, 8'h00, 8'h00, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h62, 8'h00, 8'h00, 1'b1, '{8'h62, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h63, 8'h00, 8'h00, 1'b1, '{8'h63, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h64, 8'h00, 8'h00, 1'b1, '{8'h64, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h65, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h0A, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_RECLEN), 8'd0, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h71, 8'h00, 8'h00, 1'b1, '{8'h71, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h0A, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_RECLEN), 8'd5, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h61, 8'h00, 8'h00, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h62, 8'h00, 8'h00, 1'b1, '{8'h62, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h63, 8'h00, 8'h00, 1'b1, '{8'h63, 1'b1, 1'b0, 1'b0}},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_RECLEN), 8'd2, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h0A, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_RECLEN), 8'd4, 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_XLATE), 8'd1, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h41, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_REQ, OP_EOI,   8'h00, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_MODE), 8'(MODE_UNBLOCK), 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_RECLEN), 8'd5, 1'b0, NO_OUT},
        '{ROW_CFG, OP_DATA,  8'h00, 8'(REG_XLATE), 8'd0, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h61, 8'h00, 8'h00, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h20, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h20, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h62, 8'h00, 8'h00, 1'b0, NO_OUT},
        '{ROW_REQ, OP_DATA,  8'h20, 8'h00, 8'h00, 1'b1, '{8'h0A, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_DATA,  8'h7A, 8'h00, 8'h00, 1'b1, '{8'h7A, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, OP_EOI,   8'h00, 8'h00, 8'h00, 1'b1, '{8'h0A, 1'b1, 1'b0, 1'b1}}
    };

    localparam t_setting SETTINGS_RUN [9] = '{
        '{MODE_COPY, 6'd60, 1'b1}, '{MODE_BLOCK, 6'd8, 1'b0}, '{MODE_UNBLOCK, 6'd6, 1'b1},
        '{MODE_BLOCK, 6'd63, 1'b1}, '{MODE_UNBLOCK, 6'd0, 1'b0}, '{MODE_BLOCK, 6'd1, 1'b1},
        '{MODE_UNBLOCK, 6'd60, 1'b1}, '{MODE_SPARE, 6'd17, 1'b1}, '{MODE_BLOCK, 6'd12, 1'b1}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_op;
    logic [7:0]  i_data_byte;
    logic [7:0]  i_table_index;
    logic [7:0]  i_table_value;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_truncated;
    logic        o_short_record;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int snd_idle = 0;
    int rcv_idle = 0;
    int mismatches = 0;
    int bytes_checked = 0;
    int requests_taken = 0;
    int cfg_writes = 0;

    logic       cur_typed = 1'b0;
    t_out_byte  cur_want = '0;

    logic [1:0] cfg_mode;
    logic [5:0] cfg_len;
    logic       cfg_xl;
    logic [5:0] col;
    logic       dropping;
    logic [5:0] held_sp;
    logic [7:0] xl_map [256];
    t_out_byte  conv_buf [64];
    int         conv_n;
    t_out_byte  pending_bytes [$];

    record_block_unblock_converter #(.MAX_RECORD(MAX_REC)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .o_truncated    (o_truncated),
        .o_short_record (o_short_record),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        end
    endfunction

    function automatic logic [7:0] map_byte(input logic [7:0] b);
        return cfg_xl ? xl_map[b] : b;
    endfunction

    function automatic logic [7:0] alpha_byte(input int k);
        if (k < 26) return 8'(65 + k);
        case (k)
            26: return 8'h00;
            27: return 8'hFF;
            28: return CH_NL;
            default: return CH_SP;
        endcase
    endfunction

    function automatic void stage_byte(input logic [7:0] ch, input logic tr, input logic sr);
        conv_buf[conv_n] = '{ch, 1'b0, tr, sr};
        conv_n++;
    endfunction

    function automatic void convert_request(input logic [1:0] op, input logic [7:0] raw,
                                            input logic [7:0] idx, input logic [7:0] val);
        int len;
        int k;
        logic [7:0] b;
        logic [7:0] pad;
        len = (cfg_len == 6'd0) ? 1 : ((int'(cfg_len) > MAX_REC) ? MAX_REC : int'(cfg_len));
        conv_n = 0;
        case (op)
            OP_TWR: begin
                xl_map[idx] = val;
            end
            OP_EOI: begin
                if (cfg_mode == MODE_BLOCK) begin
                    if (!dropping && col != 6'd0 && int'(col) < len) begin
                        pad = map_byte(CH_SP);
                        for (k = int'(col); k < len; k++) stage_byte(pad, k + 1 == len, 1'b0);
                    end
                end else if (cfg_mode == MODE_UNBLOCK) begin
                    if (col != 6'd0) stage_byte(CH_NL, 1'b0, 1'b1);
                end
                col = '0;
                dropping = 1'b0;
                held_sp = '0;
            end
            OP_DATA: begin
                if (cfg_mode == MODE_BLOCK) begin
                    if (dropping) begin
                        if (raw == CH_NL) dropping = 1'b0;
                    end else if (raw == CH_NL) begin
                        pad = map_byte(CH_SP);
                        for (k = int'(col); k < len; k++) stage_byte(pad, 1'b0, 1'b0);
                        col = '0;
                    end else begin
                        col = col + 6'd1;
                        if (int'(col) >= len) begin
                            stage_byte(map_byte(raw), 1'b1, 1'b0);
                            col = '0;
                            dropping = 1'b1;
                        end else begin
                            stage_byte(map_byte(raw), 1'b0, 1'b0);
                        end
                    end
                end else if (cfg_mode == MODE_UNBLOCK) begin
                    b = map_byte(raw);
                    col = col + 6'd1;
                    if (b == CH_SP) begin
                        held_sp = held_sp + 6'd1;
                    end else begin
                        for (k = 0; k < int'(held_sp); k++) stage_byte(CH_SP, 1'b0, 1'b0);
                        held_sp = '0;
                        stage_byte(b, 1'b0, 1'b0);
                    end
                    if (int'(col) >= len) begin
                        stage_byte(CH_NL, 1'b0, 1'b0);
                        col = '0;
                        held_sp = '0;
                    end
                end else begin
                    stage_byte(map_byte(raw), 1'b0, 1'b0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_result();
        t_out_byte want;
        if (pending_bytes.size() == 0) begin
            report_mismatch("result with nothing pending", 32'h0, {24'h0, o_out_byte});
        end else begin
            want = pending_bytes.pop_front();
            if (o_out_byte !== want.ch) begin
                report_mismatch("out_byte", 32'(want.ch), 32'(o_out_byte));
            end
            if (o_last !== want.last) report_mismatch("last", 32'(want.last), 32'(o_last));
            if (o_truncated !== want.trunc) begin
                report_mismatch("truncated", 32'(want.trunc), 32'(o_truncated));
            end
            if (o_short_record !== want.short_rec) begin
                report_mismatch("short_record", 32'(want.short_rec), 32'(o_short_record));
            end
        end
        bytes_checked++;
    endtask

    always @(posedge i_clk) begin : track_b
        int k;
        t_out_byte entry;
        if (!i_rst_n) begin
            cfg_mode = MODE_COPY;
            cfg_len = 6'd60;
            cfg_xl = 1'b0;
            col = '0;
            dropping = 1'b0;
            held_sp = '0;
            pending_bytes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MODE:   cfg_mode = pwdata[1:0];
                    REG_RECLEN: cfg_len = pwdata[5:0];
                    REG_XLATE:  cfg_xl = pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (push && !full) begin
                convert_request(i_op, i_data_byte, i_table_index, i_table_value);
                if (cur_typed) begin
                    pending_bytes.push_back(cur_want);
                end else begin
                    for (k = 0; k < conv_n; k++) begin
                        entry = conv_buf[k];
                        entry.last = (k == conv_n - 1);
                        pending_bytes.push_back(entry);
                    end
                end
                requests_taken++;
            end
            if (pop && !empty) check_result();
        end
    end

    always @(negedge i_clk) begin
        pop = ($urandom_range(99) >= rcv_idle);
    end

    task automatic send_request(input logic [1:0] op, input logic [7:0] data,
                                input logic [7:0] idx, input logic [7:0] val,
                                input logic typed, input t_out_byte want);
        while ($urandom_range(99) < snd_idle) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_op = op;
        i_data_byte = data;
        i_table_index = idx;
        i_table_value = val;
        cur_typed = typed;
        cur_want = want;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        push = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] reg_id, input logic [7:0] value);
        logic [31:0] mask;
        mask = (reg_id == REG_MODE) ? 32'h3 : ((reg_id == REG_RECLEN) ? 32'h3F : 32'h1);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_id, 2'b00};
        pwdata = {24'h0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== ({24'h0, value} & mask)) begin
            report_mismatch("register read back", {24'h0, value} & mask, prdata & mask);
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        cfg_writes++;
    endtask

    function automatic int pick_line_len(input int len_eff);
        int r;
        r = $urandom_range(9);
        if (r < 6) return $urandom_range(len_eff, 0);
        if (r < 8) return len_eff;
        return len_eff + $urandom_range(4, 1);
    endfunction

    task automatic run_setting(input int len_eff, input int n_items);
        int sent;
        int line_left;
        int pick;
        int r;
        logic [7:0] b;
        sent = 0;
        line_left = pick_line_len(len_eff);
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                send_request(OP_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_OUT);
            end else if (pick < 5) begin
                send_request(OP_EOI, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_OUT);
                line_left = pick_line_len(len_eff);
                sent++;
            end else if (pick < 9) begin
                send_request(OP_TWR, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_OUT);
                sent++;
            end else begin
                if (line_left == 0) begin
                    b = CH_NL;
                    line_left = pick_line_len(len_eff);
                end else begin
                    r = $urandom_range(9);
                    if (r < 3) b = CH_SP;
                    else if (r < 9) b = alpha_byte(int'($urandom_range(25)));
                    else b = alpha_byte(int'($urandom_range(28, 26)));
                    line_left--;
                end
                send_request(OP_DATA, b, 8'($urandom), 8'($urandom), 1'b0, NO_OUT);
                sent++;
            end
        end
    endtask

    initial begin
        #(LIMIT_NS);
        $display("Timeout with %0d result bytes still pending", pending_bytes.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main_b
        int k;
        int p;
        int len_eff;
        t_setting s;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_op = OP_DATA;
        i_data_byte = '0;
        i_table_index = '0;
        i_table_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        snd_idle = 26;
        rcv_idle = 56;
        // fill the table entries of every byte the random stimulus can send
        for (k = 0; k < ALPHA_N; k++) begin
            send_request(OP_TWR, 8'($urandom), alpha_byte(k),
                         (k == ALPHA_N - 1 || $urandom_range(1) == 1) ? alpha_byte(k)
                                                                      : 8'($urandom),
                         1'b0, NO_OUT);
        end

        for (k = 0; k < $size(DIRECTED); k++) begin
            if (DIRECTED[k].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(DIRECTED[k].idx[1:0], DIRECTED[k].val);
            end else begin
                send_request(DIRECTED[k].op, DIRECTED[k].data, DIRECTED[k].idx,
                             DIRECTED[k].val, DIRECTED[k].typed, DIRECTED[k].want);
            end
        end

        for (p = 0; p < 9; p++) begin
            if (p < 3) begin
                snd_idle = 26;
                rcv_idle = 56;
            end else if (p < 6) begin
                snd_idle = 56;
                rcv_idle = 26;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            s = SETTINGS_RUN[p];
            wait_idle();
            cfg_write(REG_MODE, 8'(s.mode));
            cfg_write(REG_RECLEN, 8'(s.len));
            cfg_write(REG_XLATE, 8'(s.xl));
            len_eff = (s.len == 6'd0) ? 1 : ((int'(s.len) > MAX_REC) ? MAX_REC : int'(s.len));
            run_setting(len_eff, ITEMS_PER_SETTING);
        end

        push = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d result bytes from %0d requests, %0d register writes, %0d mismatches",
                 bytes_checked, requests_taken, cfg_writes, mismatches);
        $display("Covered copy, block, unblock and spare modes, lengths 0 to 63, %s",
                 "translation on and off, three stall profiles");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> record_block_unblock_converter.f
src/rbuc_pkg.sv
src/rbuc_front.sv
src/rbuc_fifo.sv
src/rbuc_back.sv
src/record_block_unblock_converter.sv
verif/tb.sv
